[rtl/core/pog_pkg.sv]
package pog_pkg;

	localparam int SampleRateDef = 44100;

	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_NOTE  = 2'd1;
	localparam logic [1:0] OP_GLIDE = 2'd2;

	localparam logic [2:0] REG_VOLUME = 3'd0;
	localparam logic [2:0] REG_WIDTH  = 3'd1;
	localparam logic [2:0] REG_TUNE   = 3'd2;
	localparam logic [2:0] REG_OCTAVE = 3'd3;
	localparam logic [2:0] REG_PHASE  = 3'd4;

	localparam logic [1:0] LVL_ZERO = 2'd0;
	localparam logic [1:0] LVL_HIGH = 2'd1;
	localparam logic [1:0] LVL_LOW  = 2'd2;

	localparam int CfgW = 16;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [19:0] frequency;
		logic [15:0] glide_length;
	} item_t;

	typedef struct packed {
		logic [14:0] volume;
		logic [7:0]  width_q8;
		logic [13:0] tune_q12;
		logic [15:0] octave_q12;
		logic [7:0]  start_phase_q8;
	} cfg_t;

endpackage

[rtl/core/pog_front.sv]
module pog_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  pog_pkg::item_t in_item,
	output logic          q_valid,
	input  logic          q_ready,
	output pog_pkg::item_t q_item
);
	import pog_pkg::*;

	// two-entry queue; drop opcode 3 on entry
	item_t     mem_q [2];
	logic      wr_q, rd_q;
	logic [1:0] cnt_q;
	logic      push, pop, useful;

	assign in_ready = (cnt_q != 2'd2);
	assign useful   = (in_item.opcode != 2'd3);
	assign push     = in_valid && in_ready && useful;
	assign q_valid  = (cnt_q != 2'd0);
	assign pop      = q_valid && q_ready;
	assign q_item   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	a_cnt: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'd2)
		else $error("queue overflow");
	a_nopush_full: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 |-> !push) else $error("push into full queue");
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == $past(cnt_q) + 2'd1) else $error("count slip");
endmodule

[rtl/core/pog_div.sv]
module pog_div #(
	parameter int NW = 64,
	parameter int DW = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          busy,
	output logic [NW-1:0] quo
);
	// restoring divider, one quotient bit per cycle
	localparam int CW = $clog2(NW + 1);
	logic [NW-1:0] quo_q;
	logic [DW:0]   rem_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic [DW:0]   trial;
	logic [DW:0]   diff;

	assign busy  = (cnt_q != '0);
	assign quo   = quo_q;
	assign trial = {rem_q[DW-1:0], quo_q[NW-1]};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(NW);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy) begin
			if (!diff[DW]) begin
				rem_q <= diff;
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
		end
	end
endmodule

[rtl/core/pog_back.sv]
module pog_back #(
	parameter int SampleRate = pog_pkg::SampleRateDef
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	output logic           q_ready,
	input  pog_pkg::item_t q_item,
	input  pog_pkg::cfg_t  cfg,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [15:0]    sample
);
	import pog_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_PDIV = 3'd2;
	localparam logic [2:0] ST_GDIV = 3'd3;
	localparam logic [2:0] ST_MUL2 = 3'd4;
	localparam logic [2:0] ST_LOAD = 3'd5;
	localparam logic [63:0] NUM = 64'(SampleRate) << 36;

	logic [2:0]  st_q;
	logic [1:0]  lvl_q;
	logic [31:0] step_q, per_q;
	logic [19:0] freq_q, tgt_q;
	logic        gact_q;
	logic [15:0] glen_q, gpos_q;
	logic        note_q;
	logic [35:0] fo_q;
	logic [49:0] prod_q;
	logic        ov_q;
	logic [15:0] smp_q;
	logic        ov_full;
	logic        emit;

	logic        dv_start;
	logic [63:0] dv_num, dv_den, dv_quo;
	logic        dv_busy;

	pog_div #(.NW(64), .DW(64)) u_div (
		.clk, .arst_n, .start(dv_start), .num(dv_num), .den(dv_den),
		.busy(dv_busy), .quo(dv_quo)
	);

	function automatic logic [31:0] frac(input logic [31:0] p, input logic [8:0] f);
		logic [40:0] m;
		m = {9'd0, p} * {32'd0, f};
		return m[39:8];
	endfunction

	logic [1:0]  lvl_n;
	logic [31:0] step_n, step_a, thr;
	logic [32:0] step_p;
	logic        is_tick;
	logic signed [20:0] gdiff;
	logic [20:0] gabs;
	logic [16:0] grem;
	logic [19:0] gmag;
	logic [19:0] fnew;

	assign is_tick = q_item.opcode == OP_TICK && freq_q != 20'd0;
	assign q_ready = (st_q == ST_IDLE) && !ov_full;
	assign ov_full = out_valid && !out_ready;
	assign emit    = (st_q == ST_IDLE) && q_valid && q_ready && is_tick;

	always_comb begin
		step_p = {1'b0, step_q} + 33'd256;
		step_a = gact_q ? (step_p[32] ? 32'hFFFF_FFFF : step_p[31:0]) : step_q;
		thr = (lvl_q == LVL_HIGH) ? frac(per_q, {1'b0, cfg.width_q8})
		                          : frac(per_q, 9'd256 - {1'b0, cfg.width_q8});
		lvl_n = lvl_q;
		step_n = step_a;
		if (step_a > thr) begin
			lvl_n = (lvl_q == LVL_HIGH) ? LVL_LOW : LVL_HIGH;
			step_n = '0;
		end
		if (!gact_q) begin
			step_p = {1'b0, step_n} + 33'd256;
			step_n = step_p[32] ? 32'hFFFF_FFFF : step_p[31:0];
		end
		gdiff = $signed({1'b0, tgt_q}) - $signed({1'b0, freq_q});
		gabs  = gdiff[20] ? 21'(-gdiff) : 21'(gdiff);
		grem  = {1'b0, glen_q} - {1'b0, gpos_q};
		gmag  = dv_quo[19:0];
		fnew  = gdiff[20] ? 20'(freq_q - gmag) : 20'(freq_q + gmag);
	end

	always_comb begin
		dv_start = 1'b0;
		dv_num = NUM;
		dv_den = {14'd0, prod_q};
		if (st_q == ST_LOAD) begin
			dv_start = 1'b1;
		end else if (emit && gact_q && gpos_q < glen_q) begin
			dv_start = 1'b1;
			dv_num = {43'd0, gabs};
			dv_den = {47'd0, grem};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE; lvl_q <= LVL_ZERO; step_q <= '0; per_q <= '0;
			freq_q <= '0; tgt_q <= '0; gact_q <= 1'b0; glen_q <= '0;
			gpos_q <= '0; out_valid <= 1'b0; note_q <= 1'b0;
		end else begin
			if (emit) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (q_valid && q_ready) begin
						// advance the item
						if (q_item.opcode == OP_NOTE) begin
							lvl_q <= LVL_ZERO;
							freq_q <= q_item.frequency;
							note_q <= 1'b1;
							st_q <= ST_MUL;
						end else if (q_item.opcode == OP_GLIDE) begin
							tgt_q <= q_item.frequency;
							glen_q <= q_item.glide_length;
							gpos_q <= '0;
							gact_q <= 1'b1;
						end else if (is_tick) begin
							lvl_q <= lvl_n;
							step_q <= step_n;
							smp_q <= (lvl_n == LVL_HIGH) ? {1'b0, cfg.volume} :
							         (lvl_n == LVL_LOW) ? 16'(-{1'b0, cfg.volume}) : 16'd0;
							if (gact_q) begin
								if (gpos_q < glen_q) st_q <= ST_GDIV;
								else gact_q <= 1'b0;
							end
						end
					end
				end
				ST_GDIV: begin
					if (!dv_busy) begin
						freq_q <= fnew;
						gpos_q <= gpos_q + 16'd1;
						note_q <= 1'b0;
						st_q <= ST_MUL;
					end
				end
				ST_MUL: st_q <= ST_MUL2;
				ST_MUL2: st_q <= ST_LOAD;
				ST_LOAD: st_q <= ST_PDIV;
				ST_PDIV: begin
					if (!dv_busy) begin
						per_q <= (ov_q || |dv_quo[63:32]) ? 32'hFFFF_FFFF : dv_quo[31:0];
						if (note_q) begin
							step_q <= frac((ov_q || |dv_quo[63:32]) ? 32'hFFFF_FFFF
							               : dv_quo[31:0], {1'b0, cfg.start_phase_q8});
						end
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// product and zero guard; two multipliers, registered
	always_ff @(posedge clk) begin
		fo_q <= {16'd0, freq_q} * {20'd0, cfg.octave_q12};
		prod_q <= {14'd0, fo_q} * {36'd0, cfg.tune_q12};
		ov_q <= (fo_q == 36'd0) || (cfg.tune_q12 == 14'd0);
	end

	assign sample = smp_q;

	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		q_ready |-> st_q == ST_IDLE) else $error("ready outside idle");
	a_gpos: assert property (@(posedge clk) disable iff (!arst_n)
		gact_q |-> gpos_q <= glen_q) else $error("glide overrun");
	a_lvl: assert property (@(posedge clk) disable iff (!arst_n)
		lvl_q != 2'd3) else $error("bad level");
endmodule

[rtl/core/pulse_oscillator_with_glide_core.sv]
// Pulse-width square oscillator with linear glide. Items enter a two-entry
// queue and are executed by a sequencer. A note item passes two multiplier
// stages and a divider load, then a serial period divide; a gliding tick
// runs a serial delta divide, then the same period path; a plain tick or
// glide item is handled in the idle state, and an item with opcode 3 is
// dropped on entry to the queue. Configuration registers are written directly
// through cfg_we/cfg_index/cfg_data.
module pulse_oscillator_with_glide_core #(
	parameter int SampleRate = pog_pkg::SampleRateDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  opcode,
	input  logic [19:0] frequency,
	input  logic [15:0] glide_length,
	output logic        out_valid,
	input  logic        out_ready,
	output logic signed [15:0] sample,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [pog_pkg::CfgW-1:0] cfg_data
);
	import pog_pkg::*;

	cfg_t  cfg_q;
	item_t in_item, q_item;
	logic  q_valid, q_ready;
	logic [15:0] smp;

	assign in_item = '{opcode: opcode, frequency: frequency, glide_length: glide_length};
	assign sample = smp;

	// hold the configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{volume: 15'd16384, width_q8: 8'd128, tune_q12: 14'd4096,
			           octave_q12: 16'd4096, start_phase_q8: 8'd0};
		end else if (cfg_we) begin
			case (cfg_index)
				REG_VOLUME: cfg_q.volume <= cfg_data[14:0];
				REG_WIDTH:  cfg_q.width_q8 <= cfg_data[7:0];
				REG_TUNE:   cfg_q.tune_q12 <= cfg_data[13:0];
				REG_OCTAVE: cfg_q.octave_q12 <= cfg_data[15:0];
				REG_PHASE:  cfg_q.start_phase_q8 <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	pog_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .in_item,
		.q_valid, .q_ready, .q_item
	);

	pog_back #(.SampleRate(SampleRate)) u_back (
		.clk, .arst_n, .q_valid, .q_ready, .q_item, .cfg(cfg_q),
		.out_valid, .out_ready, .sample(smp)
	);
endmodule

[tb/pulse_oscillator_with_glide_scoreboard.sv]
`timescale 1ns / 100ps

module pulse_oscillator_with_glide_scoreboard (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  opcode,
	input  logic [19:0] frequency,
	input  logic [15:0] glide_length,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic signed [15:0] sample,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [pog_pkg::CfgW-1:0] cfg_data,
	output int          mismatches,
	output int          samples_due
);
	import pog_pkg::*;

	logic [14:0] volume;
	logic [7:0]  width_q8;
	logic [13:0] tune_q12;
	logic [15:0] octave_q12;
	logic [7:0]  phase_q8;

	logic [1:0]  level;
	logic [31:0] step_acc;
	logic [31:0] period;
	logic [31:0] freq_now;
	bit          gliding;
	logic [19:0] glide_goal;
	logic [15:0] glide_span;
	logic [15:0] glide_at;

	logic signed [15:0] sample_q[$];

	assign samples_due = sample_q.size();

	function automatic logic [31:0] period_for(logic [31:0] f);
		longint unsigned prod;
		longint unsigned q;
		prod = 64'(f) * 64'(octave_q12) * 64'(tune_q12);
		if (prod == 0) return 32'hFFFF_FFFF;
		q = (64'(SampleRateDef) << 36) / prod;
		return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
	endfunction

	function automatic logic [31:0] share_of_period(logic [8:0] frac);
		longint unsigned p;
		p = (64'(period) * 64'(frac)) >> 8;
		return p[31:0];
	endfunction

	function automatic void advance_step();
		step_acc = (step_acc > 32'hFFFF_FFFF - 32'd256) ? 32'hFFFF_FFFF : step_acc + 32'd256;
	endfunction

	function automatic void maybe_flip();
		if (level == LVL_HIGH) begin
			if (step_acc > share_of_period({1'b0, width_q8})) begin
				level = LVL_LOW;
				step_acc = '0;
			end
		end else begin
			if (step_acc > share_of_period(9'd256 - {1'b0, width_q8})) begin
				level = LVL_HIGH;
				step_acc = '0;
			end
		end
	endfunction

	function automatic logic signed [15:0] level_value();
		if (level == LVL_HIGH) return {1'b0, volume};
		if (level == LVL_LOW) return -$signed({1'b0, volume});
		return '0;
	endfunction

	function automatic void apply_item(logic [1:0] op, logic [19:0] f, logic [15:0] len);
		longint diff;
		longint rem;
		if (op == OP_NOTE) begin
			level = LVL_ZERO;
			freq_now = {12'd0, f};
			period = period_for(freq_now);
			step_acc = share_of_period({1'b0, phase_q8});
		end else if (op == OP_GLIDE) begin
			glide_goal = f;
			glide_span = len;
			glide_at = '0;
			gliding = 1'b1;
		end else if (op == OP_TICK && freq_now != 0) begin
			if (gliding) begin
				advance_step();
				maybe_flip();
				sample_q.push_back(level_value());
				if (glide_at < glide_span) begin
					diff = longint'(glide_goal) - longint'(freq_now);
					rem = longint'(glide_span) - longint'(glide_at);
					freq_now = 32'(longint'(freq_now) + diff / rem);
					period = period_for(freq_now);
					glide_at = glide_at + 16'd1;
				end else begin
					gliding = 1'b0;
				end
			end else begin
				maybe_flip();
				sample_q.push_back(level_value());
				advance_step();
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			volume = 15'd16384;
			width_q8 = 8'd128;
			tune_q12 = 14'd4096;
			octave_q12 = 16'd4096;
			phase_q8 = 8'd0;
			level = LVL_ZERO;
			step_acc = '0;
			period = '0;
			freq_now = '0;
			gliding = 1'b0;
			glide_goal = '0;
			glide_span = '0;
			glide_at = '0;
			sample_q.delete();
			mismatches = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (sample_q.size() == 0) begin
					$display("%0t: unexpected sample %0d", $time, sample);
					mismatches++;
				end else begin
					if (sample !== sample_q[0]) begin
						$display("%0t: sample expected %0d actual %0d", $time, sample_q[0], sample);
						mismatches++;
					end
					void'(sample_q.pop_front());
				end
			end
			if (in_valid && in_ready)
				apply_item(opcode, frequency, glide_length);
			if (cfg_we) begin
				case (cfg_index)
					REG_VOLUME: volume = cfg_data[14:0];
					REG_WIDTH: width_q8 = cfg_data[7:0];
					REG_TUNE: tune_q12 = cfg_data[13:0];
					REG_OCTAVE: octave_q12 = cfg_data[15:0];
					REG_PHASE: phase_q8 = cfg_data[7:0];
					default: ;
				endcase
			end
		end
	end

endmodule

[tb/pulse_oscillator_with_glide_core_test.sv]
`timescale 1ns / 100ps

module pulse_oscillator_with_glide_core_test;
	import pog_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  opcode;
	logic [19:0] frequency;
	logic [15:0] glide_length;
	logic        out_valid;
	logic        out_ready;
	logic signed [15:0] sample;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [CfgW-1:0] cfg_data;

	int mismatches;
	int samples_due;
	// when set, both sides run without gaps
	bit  steady;

	pulse_oscillator_with_glide_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .frequency(frequency), .glide_length(glide_length),
		.out_valid(out_valid), .out_ready(out_ready), .sample(sample),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	pulse_oscillator_with_glide_scoreboard scoreboard (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .frequency(frequency), .glide_length(glide_length),
		.out_valid(out_valid), .out_ready(out_ready), .sample(sample),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.mismatches(mismatches), .samples_due(samples_due)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop well beyond the slowest legal run.
	initial begin
		#10_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// Receiver: stall a random number of cycles before taking each sample.
	initial begin
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = steady ? 0 : $urandom_range(0, 16);
			if (stall > 0) begin
				out_ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready = 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Offer one item; return on the falling edge after it was taken.
	task automatic send_item(logic [1:0] op, logic [19:0] f, logic [15:0] len);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		opcode = op;
		frequency = f;
		glide_length = len;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// Drain all samples, then give the block time to finish a note with no sample.
	task automatic settle();
		in_valid = 1'b0;
		while (samples_due != 0) @(negedge clk);
		repeat (300) @(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [CfgW-1:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic write_all(logic [CfgW-1:0] vol, logic [CfgW-1:0] wid, logic [CfgW-1:0] tun,
			logic [CfgW-1:0] oct, logic [CfgW-1:0] ph);
		write_reg(REG_VOLUME, vol);
		write_reg(REG_WIDTH, wid);
		write_reg(REG_TUNE, tun);
		write_reg(REG_OCTAVE, oct);
		write_reg(REG_PHASE, ph);
	endtask

	// Mostly ticks, with audible notes and glides among them; a few ignored items.
	task automatic random_items(int count);
		int pick;
		logic [19:0] f;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			f = 20'($urandom_range(100, 4000) * 16 + $urandom_range(0, 15));
			if ($urandom_range(0, 9) == 0)
				f = 20'($urandom());
			if (pick < 10)
				send_item(OP_NOTE, f, 16'($urandom()));
			else if (pick < 16)
				send_item(OP_GLIDE, f, ($urandom_range(0, 9) == 0) ?
					16'($urandom()) : 16'($urandom_range(0, 24)));
			else if (pick < 19)
				send_item(2'd3, 20'($urandom()), 16'($urandom()));
			else
				send_item(OP_TICK, 20'($urandom()), 16'($urandom()));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = OP_TICK;
		frequency = '0;
		glide_length = '0;
		cfg_we = 1'b0;
		cfg_index = REG_VOLUME;
		cfg_data = '0;
		steady = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: zero frequency, unused opcode, notes at the range ends, glides.
		send_item(OP_TICK, 20'd7040, 16'hFFFF);
		send_item(2'd3, 20'hFFFFF, 16'hFFFF);
		send_item(OP_NOTE, 20'd7040, 16'd0);
		repeat (4) send_item(OP_TICK, 20'd0, 16'd0);
		send_item(OP_GLIDE, 20'd14080, 16'd0);
		repeat (3) send_item(OP_TICK, 20'd0, 16'd0);
		send_item(OP_GLIDE, 20'd3000, 16'd5);
		repeat (7) send_item(OP_TICK, 20'd0, 16'd0);
		send_item(OP_NOTE, 20'hFFFFF, 16'd0);
		repeat (3) send_item(OP_TICK, 20'd0, 16'd0);
		send_item(OP_NOTE, 20'd1, 16'd0);
		send_item(OP_GLIDE, 20'd0, 16'hFFFF);
		repeat (2) send_item(OP_TICK, 20'd0, 16'd0);
		send_item(OP_NOTE, 20'd0, 16'd0);
		send_item(OP_TICK, 20'd0, 16'd0);
		settle();

		// Extremes: silent with out-of-range widths, then loud at the top corners.
		write_all(16'h8000, 16'h0000, 16'd1024, 16'd256, 16'd0);
		send_item(OP_NOTE, 20'd20000, 16'd0);
		random_items(100);
		settle();
		write_all(16'hFFFF, 16'h00FF, 16'h3FFF, 16'hFFFF, 16'h00FF);
		steady = 1'b1;
		random_items(100);
		settle();
		steady = 1'b0;
		write_all(16'd32767, 16'd253, 16'd4096, 16'd4096, 16'd128);
		random_items(100);
		settle();

		// Random settings, including a zero tune (saturated period).
		for (int p = 0; p < 3; p++) begin
			write_all(16'($urandom()), 16'($urandom()),
				(p == 2) ? 16'd0 : 16'($urandom_range(1024, 16383)),
				16'($urandom_range(256, 65535)), 16'($urandom()));
			steady = (p == 1);
			random_items(100);
			settle();
		end
		steady = 1'b0;

		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
